// ===== hdl/smfr_pkg.sv =====
`timescale 1ns / 1ps
// smfr_pkg: shared types, constants and control-word layout for the stereo
// multitap feedback reverb. No dependencies.
package smfr_pkg;

	localparam int NUM_TAPS_DEF    = 5;
	localparam int TAP_SPACING_DEF = 960;
	localparam int RING_DEPTH_DEF  = 8192;
	localparam int STORE_WIDTH_DEF = 24;

	localparam int LANES     = 2;
	localparam int SAMPLE_W  = 16;
	localparam int DECAY_W   = 15;
	localparam int GAIN_W    = 16;
	localparam int COEF_W    = GAIN_W + 1;
	localparam int OACC_W    = 64;
	localparam int NUM_DECAY = 5;
	localparam int TAP_MAX   = 8;
	localparam int TAP_IDX_W = 3;
	localparam int TAP_CNT_W = 4;
	localparam int CFG_IDX_W = 3;

	localparam logic [GAIN_W-1:0] IN_GAIN_RST  = 16'd24576;
	localparam logic [GAIN_W-1:0] OUT_GAIN_RST = 16'd32768;

	localparam logic [CFG_IDX_W-1:0] REG_DECAY0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY4   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IN_GAIN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN = 3'd6;

	typedef logic [3:0] upc_t;

	localparam upc_t UPC_IDLE  = 4'd0;
	localparam upc_t UPC_IN    = 4'd1;
	localparam upc_t UPC_TAP   = 4'd2;
	localparam upc_t UPC_DRAIN = 4'd3;
	localparam upc_t UPC_CLAMP = 4'd4;
	localparam upc_t UPC_OLO   = 4'd5;
	localparam upc_t UPC_OHI   = 4'd6;
	localparam upc_t UPC_OSUM  = 4'd7;
	localparam upc_t UPC_ORND  = 4'd8;
	localparam upc_t UPC_FIN   = 4'd9;
	localparam upc_t UPC_RET   = 4'd10;

	typedef enum logic [2:0] {
		MS_NONE,
		MS_IN,
		MS_TAP,
		MS_OLO,
		MS_OHI
	} mul_sel_t;

	typedef enum logic [2:0] {
		AO_NONE,
		AO_ACC_SET,
		AO_ACC_ADD,
		AO_OUT_SET,
		AO_OUT_ADD_HI
	} acc_op_t;

	typedef enum logic [2:0] {
		XO_NONE,
		XO_LOAD,
		XO_CLAMP,
		XO_STQ,
		XO_ORND,
		XO_FINISH
	} xop_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_INPUT,
		C_TAP_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     rd;
		xop_t     xop;
		cond_t    cond;
		upc_t     target;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic tap_more;
		logic out_busy;
	} stat_t;

	localparam ctrl_t CTRL_NOP = '{
		mul_sel: MS_NONE,
		acc_op:  AO_NONE,
		rd:      1'b0,
		xop:     XO_NONE,
		cond:    C_NEXT,
		target:  UPC_IDLE
	};

endpackage

// ===== hdl/smfr_seq.sv =====
`timescale 1ns / 1ps
// smfr_seq: microcode ROM, step counter and branch logic of the reverb.
// Depends on smfr_pkg.
module smfr_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  smfr_pkg::stat_t stat,
	output smfr_pkg::ctrl_t ctrl
);
	import smfr_pkg::*;

	upc_t upc_q;
	upc_t upc_d;
	logic jump;

	function automatic ctrl_t ucode(input upc_t pc);
		ctrl_t c;
		c = CTRL_NOP;
		unique case (pc)
			UPC_IDLE: begin
				c.xop    = XO_LOAD;
				c.cond   = C_NO_INPUT;
				c.target = UPC_IDLE;
			end
			UPC_IN: begin
				c.mul_sel = MS_IN;
				c.acc_op  = AO_ACC_SET;
				c.rd      = 1'b1;
			end
			UPC_TAP: begin
				c.mul_sel = MS_TAP;
				c.acc_op  = AO_ACC_ADD;
				c.rd      = 1'b1;
				c.cond    = C_TAP_MORE;
				c.target  = UPC_TAP;
			end
			UPC_DRAIN: begin
			end
			UPC_CLAMP: begin
				c.xop = XO_CLAMP;
			end
			UPC_OLO: begin
				c.xop     = XO_STQ;
				c.mul_sel = MS_OLO;
				c.acc_op  = AO_OUT_SET;
			end
			UPC_OHI: begin
				c.mul_sel = MS_OHI;
				c.acc_op  = AO_OUT_ADD_HI;
			end
			UPC_OSUM: begin
			end
			UPC_ORND: begin
				c.xop = XO_ORND;
			end
			UPC_FIN: begin
				c.xop    = XO_FINISH;
				c.cond   = C_OUT_BUSY;
				c.target = UPC_FIN;
			end
			UPC_RET: begin
				c.cond   = C_ALWAYS;
				c.target = UPC_IDLE;
			end
			default: begin
				c.cond   = C_ALWAYS;
				c.target = UPC_IDLE;
			end
		endcase
		return c;
	endfunction

	always_comb begin
		ctrl = ucode(upc_q);
		unique case (ctrl.cond)
			C_NEXT:     jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_NO_INPUT: jump = !stat.in_valid;
			C_TAP_MORE: jump = stat.tap_more;
			C_OUT_BUSY: jump = stat.out_busy;
			default:    jump = 1'b1;
		endcase
		upc_d = jump ? ctrl.target : upc_q + 4'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

// ===== hdl/stereo_multitap_feedback_reverb_top.sv =====
`timescale 1ns / 1ps
// stereo_multitap_feedback_reverb_top: datapath, delay memory and config
// registers of the stereo reverb. Depends on smfr_pkg and smfr_seq.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, sample_left/right     | in
//  output  | out_valid, out_ready, out_left/right      | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// The tap loop reads one memory word (both channels) per cycle from the
// single delay RAM port. Reset needs no clearing pass: a wrap flag and the
// write pointer mark entries never written, which read as zero. Config
// registers reset to defaults.
// A stalled output holds the block at its finishing step; one result may wait
// while the next frame is accepted and computed.
module stereo_multitap_feedback_reverb_top #(
	parameter int NUM_TAPS    = smfr_pkg::NUM_TAPS_DEF,
	parameter int TAP_SPACING = smfr_pkg::TAP_SPACING_DEF,
	parameter int RING_DEPTH  = smfr_pkg::RING_DEPTH_DEF,
	parameter int STORE_WIDTH = smfr_pkg::STORE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [smfr_pkg::SAMPLE_W-1:0]  sample_left,
	input  logic signed [smfr_pkg::SAMPLE_W-1:0]  sample_right,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [smfr_pkg::SAMPLE_W-1:0]  out_left,
	output logic signed [smfr_pkg::SAMPLE_W-1:0]  out_right,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [smfr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [smfr_pkg::GAIN_W-1:0]           cfg_data
);
	import smfr_pkg::*;

	localparam int SW    = STORE_WIDTH;
	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int MA    = (SW > 25) ? SW : 25;
	localparam int PW    = MA + COEF_W;
	localparam int AW    = (SW + 19 > 48) ? SW + 19 : 48;
	localparam int OW    = OACC_W;

	localparam logic [PTR_W:0] RD_EXT = (PTR_W + 1)'(RING_DEPTH);
	localparam logic [PTR_W-1:0] WP_LAST = PTR_W'(RING_DEPTH - 1);
	localparam logic [TAP_CNT_W-1:0] TAPS = TAP_CNT_W'(NUM_TAPS);
	localparam logic [TAP_CNT_W-1:0] TAP_LAST = TAP_CNT_W'(NUM_TAPS - 1);

	localparam logic signed [AW-1:0] ACC_MAX = AW'(1) <<< 46;
	localparam logic signed [AW-1:0] ACC_MIN = -ACC_MAX;
	localparam logic signed [AW-1:0] SMAX    = (AW'(1) <<< (SW - 1)) - AW'(1);
	localparam logic signed [AW-1:0] SMIN    = ~SMAX;
	localparam logic signed [AW-1:0] S_BIAS  = AW'(32'sd32767);
	localparam logic signed [OW-1:0] O_BIAS  = (OW'(1) <<< 30) - OW'(1);
	localparam logic signed [OW-1:0] OUT_MAX = 64'sd32767;
	localparam logic signed [OW-1:0] OUT_MIN = -64'sd32768;

	ctrl_t ctrl;
	stat_t stat;

	logic [DECAY_W-1:0] decay_q [NUM_DECAY];
	logic [GAIN_W-1:0]  ig_q;
	logic [GAIN_W-1:0]  og_q;

	logic [PTR_W-1:0]     wp_q;
	logic                 wrap_q;
	logic [TAP_CNT_W-1:0] rtap_q;
	logic [TAP_CNT_W-1:0] mtap_q;
	logic                 rdv_q;
	logic                 out_valid_q;
	acc_op_t              acc_op_s1;

	logic [2*SW-1:0] mem [RING_DEPTH];
	logic [2*SW-1:0] rd_word_q;

	logic [PTR_W-1:0] tap_dist [TAP_MAX];
	logic [PTR_W-1:0] dsel;
	logic [PTR_W-1:0] rd_addr;
	logic [PTR_W:0]   wrap_sum;
	logic [DECAY_W-1:0] tap_w;

	logic ld_en;
	logic fin_en;
	logic out_busy;

	logic signed [SAMPLE_W-1:0] in_smp  [LANES];
	logic signed [SAMPLE_W-1:0] smp_q   [LANES];
	logic signed [SW-1:0]       rd_lane [LANES];
	logic signed [PW-1:0]       prod_s1 [LANES];
	logic signed [AW-1:0]       acc_q   [LANES];
	logic signed [OW-1:0]       oacc_q  [LANES];
	logic signed [SW-1:0]       wdat_q  [LANES];
	logic signed [SAMPLE_W-1:0] res_q   [LANES];

	smfr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	assign out_busy = out_valid_q && !out_ready;
	assign ld_en    = (ctrl.xop == XO_LOAD) && in_valid;
	assign fin_en   = (ctrl.xop == XO_FINISH) && !out_busy;

	assign stat.in_valid = in_valid;
	assign stat.tap_more = (mtap_q != TAP_LAST);
	assign stat.out_busy = out_busy;

	assign in_ready  = (ctrl.xop == XO_LOAD);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_left  = res_q[0];
	assign out_right = res_q[1];

	assign in_smp[0]  = sample_left;
	assign in_smp[1]  = sample_right;
	assign rd_lane[0] = rd_word_q[SW-1:0];
	assign rd_lane[1] = rd_word_q[2*SW-1:SW];

	for (genvar t = 0; t < TAP_MAX; t++) begin : g_dist
		localparam int DIST = (t < NUM_TAPS) ? ((t + 1) * TAP_SPACING) % RING_DEPTH : 0;
		assign tap_dist[t] = PTR_W'(DIST);
	end

	// tap address behind the write pointer, wrapped into the ring
	always_comb begin
		wrap_sum = '0;
		dsel = (rtap_q < TAPS) ? tap_dist[rtap_q[TAP_IDX_W-1:0]] : '0;
		if (wp_q >= dsel) begin
			rd_addr = wp_q - dsel;
		end else begin
			wrap_sum = {1'b0, wp_q} + RD_EXT - {1'b0, dsel};
			rd_addr  = wrap_sum[PTR_W-1:0];
		end
		tap_w = (mtap_q < TAP_CNT_W'(NUM_DECAY)) ? decay_q[mtap_q[TAP_IDX_W-1:0]] : '0;
	end

	always_ff @(posedge clk) begin
		if (fin_en) begin
			mem[wp_q] <= {wdat_q[1], wdat_q[0]};
		end
		if (ctrl.rd) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DECAY; i++) begin
				decay_q[i] <= '0;
			end
			ig_q        <= IN_GAIN_RST;
			og_q        <= OUT_GAIN_RST;
			wp_q        <= '0;
			wrap_q      <= 1'b0;
			rtap_q      <= '0;
			mtap_q      <= '0;
			rdv_q       <= 1'b0;
			out_valid_q <= 1'b0;
			acc_op_s1   <= AO_NONE;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_DECAY0, REG_DECAY1, REG_DECAY2, REG_DECAY3, REG_DECAY4: begin
						decay_q[cfg_index] <= cfg_data[DECAY_W-1:0];
					end
					REG_IN_GAIN:  ig_q <= cfg_data;
					REG_OUT_GAIN: og_q <= cfg_data;
					default: begin
					end
				endcase
			end
			acc_op_s1 <= ctrl.acc_op;
			if (ld_en) begin
				rtap_q <= '0;
				mtap_q <= '0;
			end else begin
				if (ctrl.rd) begin
					rtap_q <= rtap_q + 1'b1;
				end
				if (ctrl.mul_sel == MS_TAP) begin
					mtap_q <= mtap_q + 1'b1;
				end
			end
			if (ctrl.rd) begin
				rdv_q <= wrap_q || (rd_addr < wp_q);
			end
			if (fin_en) begin
				out_valid_q <= 1'b1;
				if (wp_q == WP_LAST) begin
					wp_q   <= '0;
					wrap_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic signed [MA-1:0]     mul_a;
		logic signed [COEF_W-1:0] mul_b;
		logic signed [SW-1:0]     tv;
		logic signed [AW-1:0]     st_t;
		logic signed [AW-1:0]     st_q;
		logic signed [SW-1:0]     st_sat;
		logic signed [OW-1:0]     or_t;
		logic signed [SAMPLE_W-1:0] out_sat;

		always_comb begin
			tv = rdv_q ? rd_lane[l] : '0;
			unique case (ctrl.mul_sel)
				MS_IN: begin
					mul_a = MA'(smp_q[l]);
					mul_b = $signed({1'b0, ig_q});
				end
				MS_TAP: begin
					mul_a = MA'(tv);
					mul_b = $signed({2'b00, tap_w});
				end
				MS_OLO: begin
					mul_a = MA'($signed({1'b0, acc_q[l][23:0]}));
					mul_b = $signed({1'b0, og_q});
				end
				MS_OHI: begin
					mul_a = MA'($signed(acc_q[l][47:24]));
					mul_b = $signed({1'b0, og_q});
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end

		// truncate toward zero, then saturate
		always_comb begin
			st_t = acc_q[l] + (acc_q[l][AW-1] ? S_BIAS : AW'(0));
			st_q = st_t >>> 15;
			if (st_q > SMAX) begin
				st_sat = SMAX[SW-1:0];
			end else if (st_q < SMIN) begin
				st_sat = SMIN[SW-1:0];
			end else begin
				st_sat = st_q[SW-1:0];
			end
			or_t = oacc_q[l] + (oacc_q[l][OW-1] ? O_BIAS : OW'(0));
			if (oacc_q[l] > OUT_MAX) begin
				out_sat = OUT_MAX[SAMPLE_W-1:0];
			end else if (oacc_q[l] < OUT_MIN) begin
				out_sat = OUT_MIN[SAMPLE_W-1:0];
			end else begin
				out_sat = oacc_q[l][SAMPLE_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (ld_en) begin
				smp_q[l] <= in_smp[l];
			end
			prod_s1[l] <= mul_a * mul_b;
			unique case (acc_op_s1)
				AO_ACC_SET:    acc_q[l]  <= AW'(prod_s1[l]);
				AO_ACC_ADD:    acc_q[l]  <= acc_q[l] + AW'(prod_s1[l]);
				AO_OUT_SET:    oacc_q[l] <= OW'(prod_s1[l]);
				AO_OUT_ADD_HI: oacc_q[l] <= oacc_q[l] + (OW'(prod_s1[l]) <<< 24);
				default: begin
				end
			endcase
			if (ctrl.xop == XO_CLAMP) begin
				if (acc_q[l] > ACC_MAX) begin
					acc_q[l] <= ACC_MAX;
				end else if (acc_q[l] < ACC_MIN) begin
					acc_q[l] <= ACC_MIN;
				end
			end
			if (ctrl.xop == XO_STQ) begin
				wdat_q[l] <= st_sat;
			end
			if (ctrl.xop == XO_ORND) begin
				oacc_q[l] <= or_t >>> 30;
			end
			if (fin_en) begin
				res_q[l] <= out_sat;
			end
		end
	end

	a_idle_no_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (acc_op_s1 == AO_NONE))
		else $error("accumulate pending while waiting for input");

	a_wp_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(wp_q) |-> $past(fin_en))
		else $error("write pointer moved without a finished frame");

	a_rise_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fin_en))
		else $error("result raised without a finished frame");

	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fin_en |=> out_valid_q)
		else $error("finished frame not presented");

	a_tap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mtap_q <= TAPS)
		else $error("tap counter ran past the last tap");

endmodule

// ===== verif/stereo_multitap_feedback_reverb_top_test.sv =====
`timescale 1ns / 1ps
// stereo_multitap_feedback_reverb_top_test: self-checking bench for the stereo reverb.
// A bit-exact frame predictor with its own delay rings checks every output transaction.
// Depends on smfr_pkg and stereo_multitap_feedback_reverb_top.
module stereo_multitap_feedback_reverb_top_test;
	import smfr_pkg::*;

	localparam int        RING       = RING_DEPTH_DEF;
	localparam int        PTR_W      = $clog2(RING);
	localparam int        STORE_W    = STORE_WIDTH_DEF;
	localparam int        HOLD_CYCLES = 300;
	localparam longint    ACC_LIMIT  = 64'sd1 <<< 46;
	localparam longint    Q30        = 64'sd1 <<< 30;
	localparam longint    STORE_MAX  = (64'sd1 <<< (STORE_W - 1)) - 1;
	localparam longint    STORE_MIN  = -STORE_MAX - 1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [STORE_W-1:0]  echo_word_t;
	typedef struct packed {
		sample_t left;
		sample_t right;
	} frame_t;

	localparam sample_t FULL_POS = 16'sh7FFF;
	localparam sample_t FULL_NEG = 16'sh8000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	sample_t               sample_left;
	sample_t               sample_right;
	logic                  out_valid;
	logic                  out_ready;
	sample_t               out_left;
	sample_t               out_right;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [GAIN_W-1:0]     cfg_data;

	echo_word_t            echo_ring[2][RING];
	logic [PTR_W-1:0]      head;
	logic [DECAY_W-1:0]    tap_weight[NUM_DECAY];
	logic [GAIN_W-1:0]     in_gain;
	logic [GAIN_W-1:0]     wet_gain;

	frame_t                expected_mix[$];
	frame_t                want;
	int                    mismatch_count = 0;
	bit                    idle_on = 1'b0;
	logic                  sink_hold = 1'b0;
	event                  hold_output;

	stereo_multitap_feedback_reverb_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_left  (sample_left),
		.sample_right (sample_right),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_left     (out_left),
		.out_right    (out_right),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// one channel of one frame: taps, output scaling, write-back
	function automatic sample_t reverb_lane(input int lane, input sample_t x);
		longint           acc;
		longint           mixed;
		longint           kept;
		logic [PTR_W-1:0] rd;
		acc = longint'(x) * longint'(in_gain);
		for (int t = 0; t < NUM_TAPS_DEF; t++) begin
			rd = head - PTR_W'(((t + 1) * TAP_SPACING_DEF) % RING);
			if (t < NUM_DECAY)
				acc += longint'(echo_ring[lane][rd]) * longint'(tap_weight[t]);
		end
		if (acc > ACC_LIMIT) acc = ACC_LIMIT;
		if (acc < -ACC_LIMIT) acc = -ACC_LIMIT;
		mixed = (acc * longint'(wet_gain)) / Q30;
		if (mixed > 32767) mixed = 32767;
		if (mixed < -32768) mixed = -32768;
		kept = acc / 32768;
		if (kept > STORE_MAX) kept = STORE_MAX;
		if (kept < STORE_MIN) kept = STORE_MIN;
		echo_ring[lane][head] = echo_word_t'(kept);
		return sample_t'(mixed);
	endfunction

	task automatic predict_frame(input sample_t l, input sample_t r);
		frame_t f;
		f.left  = reverb_lane(0, l);
		f.right = reverb_lane(1, r);
		head++;
		expected_mix.push_back(f);
	endtask

	task automatic reset_predictor();
		for (int i = 0; i < RING; i++) begin
			echo_ring[0][i] = '0;
			echo_ring[1][i] = '0;
		end
		head = '0;
		for (int t = 0; t < NUM_DECAY; t++)
			tap_weight[t] = '0;
		in_gain  = IN_GAIN_RST;
		wet_gain = OUT_GAIN_RST;
	endtask

	task automatic send_frame(input sample_t l, input sample_t r);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		sample_left  <= l;
		sample_right <= r;
		do @(posedge clk); while (!in_ready);
		predict_frame(l, r);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DECAY0, REG_DECAY1, REG_DECAY2, REG_DECAY3, REG_DECAY4:
				tap_weight[idx - REG_DECAY0] = data[DECAY_W-1:0];
			REG_IN_GAIN:  in_gain  = data;
			REG_OUT_GAIN: wet_gain = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// drain all outstanding frames, then let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_mix.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0:       return sample_t'(32767);
			1:       return sample_t'(-32768);
			2:       return sample_t'(int'($urandom_range(0, 63)) - 32);
			default: return sample_t'($urandom());
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return 16'd0;
			1:       return 16'd32768;
			2:       return 16'hFFFF;
			3:       return GAIN_W'($urandom());
			default: return GAIN_W'($urandom_range(8192, 32768));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_decay();
		case ($urandom_range(0, 5))
			0:       return 16'd0;
			1:       return 16'd32767;
			2:       return GAIN_W'($urandom());
			default: return GAIN_W'($urandom_range(0, 6000));
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_frame(FULL_POS, FULL_NEG);
		send_frame(FULL_NEG, FULL_POS);
		send_frame(16'sd0, 16'sd0);
		send_frame(-16'sd1, 16'sd1);
		send_frame(16'sd1, -16'sd1);
		send_frame(16'sd16384, -16'sd16384);
	endtask

	task automatic test_gain_extremes();
		wait_idle();
		write_register(REG_IN_GAIN, 16'hFFFF);
		write_register(REG_OUT_GAIN, 16'hFFFF);
		send_frame(FULL_POS, FULL_NEG);
		send_frame(FULL_NEG, FULL_POS);
		send_frame(16'sd100, -16'sd100);
		wait_idle();
		write_register(REG_IN_GAIN, 16'd0);
		send_frame(FULL_POS, FULL_NEG);
		wait_idle();
		write_register(REG_IN_GAIN, 16'd32768);
		write_register(REG_OUT_GAIN, 16'd0);
		send_frame(FULL_NEG, FULL_POS);
		wait_idle();
		write_register(REG_OUT_GAIN, 16'd32768);
		send_frame(FULL_NEG, FULL_POS);
		send_frame(16'sd12345, -16'sd54);
	endtask

	// top bit of decay data is dropped; index 7 hits no register
	task automatic test_register_edges();
		wait_idle();
		for (int t = 0; t < NUM_DECAY; t++)
			write_register(CFG_IDX_W'(REG_DECAY0 + t), 16'hFFFF);
		write_register(REG_UNUSED, 16'h0000);
		write_register(REG_IN_GAIN, 16'd16384);
		send_frame(FULL_POS, FULL_NEG);
		send_frame(-16'sd7, 16'sd7);
	endtask

	// first phase keeps the masked full-scale decays past the first tap distance
	task automatic test_random_phases();
		int n;
		for (int phase = 0; phase < 5; phase++) begin
			if (phase > 0) begin
				wait_idle();
				for (int t = 0; t < NUM_DECAY; t++)
					write_register(CFG_IDX_W'(REG_DECAY0 + t), pick_decay());
				if ($urandom_range(0, 2) == 0)
					write_register(REG_UNUSED, GAIN_W'($urandom()));
				write_register(REG_IN_GAIN, pick_gain());
				write_register(REG_OUT_GAIN, pick_gain());
			end
			idle_on = ($urandom_range(0, 3) != 0);
			n = (phase == 0) ? 1000 : 100;
			for (int i = 0; i < n; i++)
				send_frame(pick_sample(), pick_sample());
		end
	endtask

	task automatic test_output_backpressure();
		idle_on = 1'b0;
		-> hold_output;
		for (int i = 0; i < 12; i++)
			send_frame(pick_sample(), pick_sample());
	endtask

	// full-scale feedback with maximum input drive
	task automatic test_store_saturation();
		wait_idle();
		idle_on = 1'b0;
		for (int t = 0; t < NUM_DECAY; t++)
			write_register(CFG_IDX_W'(REG_DECAY0 + t), 16'd32767);
		write_register(REG_IN_GAIN, 16'hFFFF);
		write_register(REG_OUT_GAIN, 16'd1);
		for (int i = 0; i < 600; i++)
			send_frame(FULL_POS, FULL_NEG);
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold) begin
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 5) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		forever begin
			@(hold_output);
			@(posedge clk);
			sink_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			sink_hold <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_mix.size() == 0) begin
				$error("unexpected output transaction: out_left %0d out_right %0d",
					out_left, out_right);
				mismatch_count++;
			end else begin
				want = expected_mix.pop_front();
				if (out_left !== want.left) begin
					$error("out_left: expected %0d, actual %0d", want.left, out_left);
					mismatch_count++;
				end
				if (out_right !== want.right) begin
					$error("out_right: expected %0d, actual %0d", want.right, out_right);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("stereo_multitap_feedback_reverb_top verification failed");
		$finish;
	end

	initial begin
		reset_predictor();
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		sample_left  <= '0;
		sample_right <= '0;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_DECAY0;
		cfg_data     <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_gain_extremes();
		test_register_edges();
		test_random_phases();
		test_output_backpressure();
		test_store_saturation();

		in_valid <= 1'b0;
		while (expected_mix.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && expected_mix.size() == 0)
			$display("stereo_multitap_feedback_reverb_top verification clean");
		else
			$display("stereo_multitap_feedback_reverb_top verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/smfr_pkg.sv
hdl/smfr_seq.sv
hdl/stereo_multitap_feedback_reverb_top.sv
verif/stereo_multitap_feedback_reverb_top_test.sv
